@@ sv/lfrt_pkg.sv @@
// Shared types and constants for the largest-free-region tracker.
// No dependencies.
package lfrt_pkg;
	localparam int unsigned DEF_MAX_SLOTS = 16;
	localparam int unsigned DEF_ADDR_BITS = 48;
	localparam int unsigned LEN_BITS = 5;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ  = 2'd2,
		OP_RSVD  = 2'd3
	} op_t;

	localparam logic [3:0] TYPE_FREE     = 4'd0;
	localparam logic [3:0] TYPE_RESERVED = 4'd1;

	typedef struct packed {
		logic [1:0]  operation;
		logic [3:0]  region_type;
		logic        base_given;
		logic [47:0] region_base;
		logic [47:0] region_size;
		logic [3:0]  entry_index;
	} req_t;

	typedef struct packed {
		logic [47:0] free_total;
		logic [47:0] reserved_total;
		logic [47:0] committed_total;
		logic [47:0] entry_base;
		logic [47:0] entry_size;
		logic        merged;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture request, do sums and last block
		logic cfg_wr;    // latch new length
		logic scan_init; // set scan pointer for a grown block
		logic scan_step; // test one slot, move down
		logic shift_init;
		logic shift_step; // test slot j, shift or place
		logic clr_step;   // zero one slot's size (its base too on a length write)
		logic emit;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_place; // free add that qualifies for the list
		logic grew;
		logic scan_done;
		logic shift_done;
		logic clr_done;
		logic is_clear;
	} sts_t;
endpackage

@@ sv/lfrt_ctrl.sv @@
// Sequencer for the largest-free-region tracker.
// Depends on lfrt_pkg.
module lfrt_ctrl
	import lfrt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  sts_t sts,
	output cmd_t cmd
);
	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_DECID = 7'b0000010,
		ST_SCAN  = 7'b0000100,
		ST_SHIFT = 7'b0001000,
		ST_CLR   = 7'b0010000,
		ST_EMIT  = 7'b0100000,
		ST_CFGC  = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE) && !start;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = ST_DECID;
				end else if (cfg_valid) begin
					cmd.cfg_wr = 1'b1;
					state_d = ST_CFGC;
				end
			end
			ST_DECID: begin
				if (sts.is_clear) begin
					state_d = ST_CLR;
				end else if (!sts.need_place) begin
					state_d = ST_EMIT;
				end else if (sts.grew) begin
					cmd.scan_init = 1'b1;
					state_d = ST_SCAN;
				end else begin
					cmd.shift_init = 1'b1;
					state_d = ST_SHIFT;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) state_d = ST_SHIFT;
			end
			ST_SHIFT: begin
				cmd.shift_step = 1'b1;
				if (sts.shift_done) state_d = ST_EMIT;
			end
			ST_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) state_d = ST_EMIT;
			end
			ST_CFGC: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) state_d = ST_IDLE;
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end
endmodule

@@ sv/lfrt_dp.sv @@
// Datapath of the largest-free-region tracker: sums, last block, slot list.
// Depends on lfrt_pkg.
module lfrt_dp
	import lfrt_pkg::*;
#(
	parameter int unsigned MAX_SLOTS = DEF_MAX_SLOTS,
	parameter int unsigned ADDR_BITS = DEF_ADDR_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  req_t                req,
	input  logic [LEN_BITS-1:0] cfg_data,
	input  cmd_t                cmd,
	output sts_t                sts,
	output logic                done,
	output rsp_t                rsp
);
	localparam int unsigned IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int unsigned CW = $clog2(MAX_SLOTS + 1) + 1;
	localparam int unsigned LW = (CW > LEN_BITS) ? CW : LEN_BITS;
	localparam logic signed [CW:0] J_ONE = (CW+1)'(1);
	localparam logic signed [CW:0] J_TWO = (CW+1)'(2);
	typedef logic [ADDR_BITS-1:0] a_t;

	a_t slot_base_q [MAX_SLOTS];
	a_t slot_size_q [MAX_SLOTS];
	a_t free_q, rsv_q, com_q, lb_base_q, lb_size_q, prev_end_q;
	logic [3:0] lb_type_q;
	logic lb_valid_q;
	logic [CW-1:0] n_q;
	logic [3:0] idx_q;
	logic merged_q, grew_q, place_q, clr_mode_q;
	a_t nsize_q, nbase_q, old_q;
	logic signed [CW:0] j_q;
	logic [CW-1:0] ci_q;

	// combinational view of the request
	a_t base_c, size_c, end_c;
	logic join_c;
	logic [LW-1:0] len_c;
	logic [CW-1:0] n_c;
	assign base_c = req.base_given ? a_t'(req.region_base) : prev_end_q;
	assign size_c = a_t'(req.region_size);
	assign end_c  = lb_base_q + lb_size_q;
	assign join_c = lb_valid_q && (lb_type_q == req.region_type) && (end_c == base_c);
	assign len_c  = LW'(cfg_data);
	assign n_c    = (len_c > LW'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : CW'(len_c);

	logic [IW-1:0] jx, jx1, bot;
	assign jx  = j_q[IW-1:0];
	assign jx1 = IW'(j_q + J_ONE);
	assign bot = IW'(n_q - CW'(1));
	a_t bot_size;
	assign bot_size = slot_size_q[bot];

	assign sts.is_clear   = clr_mode_q;
	assign sts.grew       = grew_q;
	assign sts.need_place = place_q && (n_q != '0) && (bot_size < nsize_q);
	assign sts.scan_done  = j_q[CW] || (slot_size_q[jx] > old_q) ||
		(slot_base_q[jx] == nbase_q);
	assign sts.shift_done = j_q[CW] || (slot_size_q[jx] >= nsize_q);
	assign sts.clr_done   = (ci_q >= CW'(MAX_SLOTS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= '0; rsv_q <= '0; com_q <= '0;
			lb_valid_q <= 1'b0; lb_type_q <= '0; lb_base_q <= '0; lb_size_q <= '0;
			prev_end_q <= '1;
			n_q <= CW'(MAX_SLOTS);
			for (int i = 0; i < MAX_SLOTS; i++) begin
				slot_base_q[i] <= '0;
				slot_size_q[i] <= '0;
			end
			done <= 1'b0;
			idx_q <= '0;
			nsize_q <= '0; nbase_q <= '0; old_q <= '0;
			merged_q <= 1'b0; grew_q <= 1'b0; place_q <= 1'b0; clr_mode_q <= 1'b0;
			j_q <= '0; ci_q <= '0;
		end else begin
			done <= cmd.emit;
			if (cmd.cfg_wr) begin
				n_q <= n_c;
				ci_q <= n_c;
				clr_mode_q <= 1'b0;
			end
			if (cmd.load) begin
				idx_q <= req.entry_index;
				merged_q <= 1'b0; grew_q <= 1'b0; place_q <= 1'b0;
				clr_mode_q <= (op_t'(req.operation) == OP_CLEAR);
				ci_q <= '0;
				if (op_t'(req.operation) == OP_ADD) begin
					if (req.region_type == TYPE_FREE) free_q <= free_q + size_c;
					else if (req.region_type == TYPE_RESERVED) rsv_q <= rsv_q + size_c;
					else com_q <= com_q + size_c;
					if (join_c) begin
						lb_size_q <= lb_size_q + size_c;
						merged_q <= 1'b1;
						nsize_q <= lb_size_q + size_c;
						nbase_q <= lb_base_q;
					end else begin
						lb_valid_q <= 1'b1;
						lb_type_q <= req.region_type;
						lb_base_q <= base_c;
						lb_size_q <= size_c;
						nsize_q <= size_c;
						nbase_q <= base_c;
					end
					old_q <= lb_size_q;
					grew_q <= join_c;
					place_q <= (req.region_type == TYPE_FREE);
					prev_end_q <= base_c + size_c;
				end else if (op_t'(req.operation) == OP_CLEAR) begin
					free_q <= '0; rsv_q <= '0; com_q <= '0;
					lb_valid_q <= 1'b0; lb_type_q <= '0; lb_base_q <= '0; lb_size_q <= '0;
					prev_end_q <= '1;
				end
			end
			if (cmd.scan_init) begin
				j_q <= $signed({1'b0, n_q}) - J_ONE;
			end
			if (cmd.scan_step) begin
				if (!j_q[CW] && !(slot_size_q[jx] > old_q) &&
					(slot_base_q[jx] == nbase_q)) begin
					slot_size_q[jx] <= nsize_q;
					j_q <= j_q - J_ONE;
				end else if (sts.scan_done) begin
					j_q <= $signed({1'b0, n_q}) - J_TWO;
				end else begin
					j_q <= j_q - J_ONE;
				end
			end
			if (cmd.shift_init) j_q <= $signed({1'b0, n_q}) - J_TWO;
			if (cmd.shift_step) begin
				if (sts.shift_done) begin
					slot_size_q[jx1] <= nsize_q;
					slot_base_q[jx1] <= nbase_q;
				end else begin
					slot_size_q[jx1] <= slot_size_q[jx];
					slot_base_q[jx1] <= slot_base_q[jx];
					j_q <= j_q - J_ONE;
				end
			end
			if (cmd.clr_step) begin
				if (ci_q < CW'(MAX_SLOTS)) begin
					slot_size_q[ci_q[IW-1:0]] <= '0;
					if (!clr_mode_q) slot_base_q[ci_q[IW-1:0]] <= '0;
				end
				ci_q <= ci_q + CW'(1);
			end
		end
	end

	logic idx_ok;
	assign idx_ok = (32'(idx_q) < MAX_SLOTS);
	always_comb begin
		rsp = '0;
		rsp.free_total      = 48'(free_q);
		rsp.reserved_total  = 48'(rsv_q);
		rsp.committed_total = 48'(com_q);
		rsp.merged          = merged_q;
		if (idx_ok) begin
			rsp.entry_base = 48'(slot_base_q[IW'(idx_q)]);
			rsp.entry_size = 48'(slot_size_q[IW'(idx_q)]);
		end
	end
endmodule

@@ sv/largest_free_region_tracker_unit.sv @@
// Top level of the largest-free-region tracker.
// Depends on lfrt_pkg, lfrt_ctrl, lfrt_dp.
// One item at a time: an add loads, decides and emits, and when a free block enters the list
// it also scans for a grown block, then does the insertion shift, one slot per cycle.
// A clear sweeps all slots and a length write sweeps the slots at and above the new length. The
// result shows for one cycle with done high; the receiver cannot stall.
module largest_free_region_tracker_unit
	import lfrt_pkg::*;
#(
	parameter int unsigned MAX_SLOTS = DEF_MAX_SLOTS,
	parameter int unsigned ADDR_BITS = DEF_ADDR_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  req_t                req,
	output logic                done,
	output rsp_t                rsp,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [LEN_BITS-1:0] cfg_data
);
	cmd_t cmd;
	sts_t sts;

	lfrt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .sts(sts), .cmd(cmd)
	);

	lfrt_dp #(.MAX_SLOTS(MAX_SLOTS), .ADDR_BITS(ADDR_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .req(req), .cfg_data(cfg_data),
		.cmd(cmd), .sts(sts), .done(done), .rsp(rsp)
	);
endmodule

@@ sv/lfrt_chk.sv @@
// Port checker for the largest-free-region tracker, bound to the top level.
// Depends on lfrt_pkg.
module lfrt_chk
	import lfrt_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic cfg_valid,
	input logic cfg_ready,
	input rsp_t rsp
);
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accept without busy");
	a_done1: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one beat");
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready |-> !busy) else $error("cfg ready while busy");
	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> busy) else $error("cfg beat without sweep");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && !$isunknown(rsp)) else $error("bad result beat");
endmodule

bind largest_free_region_tracker_unit lfrt_chk u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .rsp(rsp)
);
